@@ rtl/core/shltok_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shltok_pkg
// Shared constants, byte classes and beat layouts for the command line lexer.
// ----------------------------------------------------------------------------
package shltok_pkg;

  // Default size of the word store.
  localparam int MAX_WORDS_DEF = 32;

  // Widths fixed by the beat layouts.
  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 6;
  localparam int IN_DW    = 8;
  localparam int OUT_DW   = 16;
  localparam int MODE_W   = 3;

  // Lexer modes.
  localparam logic [MODE_W-1:0] MODE_BETWEEN = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PLAIN   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SPECIAL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUOTE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd4;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_PLAIN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUOTED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SPECIAL = 2'd2;

  // Byte codes the lexer reacts to.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQUOT = 8'h22;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SQUOT = 8'h27;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_BTICK = 8'h60;
  localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_EOF   = 8'hFF;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_EOF) || (c == CH_NUL);
  endfunction

  function automatic logic is_sign(input logic [CHAR_W-1:0] c);
    return (c == CH_PIPE) || (c == CH_GT);
  endfunction

  function automatic logic is_quote(input logic [CHAR_W-1:0] c);
    return (c == CH_DQUOT) || (c == CH_SQUOT) || (c == CH_BTICK);
  endfunction

  // Result beat payload, highest bit first.
  typedef struct packed {
    logic [OUT_DW-12:0] pad;
    logic               store_overflow;
    logic               empty_line;
    logic [IDX_W-1:0]   word_index;
    logic               in_token;
    logic               becomes_terminator;
    logic               token_start;
  } out_data_t;

endpackage

@@ rtl/core/shell_line_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// Lexes a command line one byte per beat and marks token boundaries,
// token kinds and terminators for every byte.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   in_      slave      tdata: char_in; tlast: last_char
//   out_     master     tdata: token flags, word_index, empty_line, overflow;
//                       tuser: token_kind; tlast: line_done
//
// Every byte gives exactly one result beat, in the cycle after it is accepted.
// A new byte is taken in every cycle; the figure is set by the single result
// register, which also parts the two sides so that input keeps flowing while
// the sink takes the previous result. The lexer state (mode, open quote,
// word count, overflow flag) updates in the cycle of acceptance.
// Reset (rst_n low, synchronous) empties the result register and returns
// the lexer to between-tokens with an empty word store. If out_tready is
// low while a result waits, in_tready drops until that result is taken.
// The lexer state also returns to its reset value after each line's last byte.
//
module shell_line_tokenizer #(
  parameter int MaxWords = shltok_pkg::MAX_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [shltok_pkg::IN_DW-1:0]  in_tdata,   // [7:0] char_in
  input  logic                          in_tlast,   // last_char
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] token_start, [1] becomes_terminator, [2] in_token,
  // [8:3] word_index, [9] empty_line, [10] store_overflow, [15:11] zero
  output logic [shltok_pkg::OUT_DW-1:0] out_tdata,
  output logic [shltok_pkg::KIND_W-1:0] out_tuser,  // [1:0] token_kind
  output logic                          out_tlast   // line_done
);
  import shltok_pkg::*;

  // The word count must be able to hold MaxWords itself.
  localparam int WC_W = $clog2(MaxWords + 1);
  localparam logic [WC_W-1:0]  WC_MAX  = WC_W'(MaxWords);
  localparam logic [IDX_W-1:0] OVF_IDX = IDX_W'(MaxWords);

  // Lexer state.
  logic [MODE_W-1:0] mode_r,  mode_nxt;
  logic [CHAR_W-1:0] quote_r, quote_nxt;
  logic [WC_W-1:0]   wc_r,    wc_nxt;
  logic              ovf_r,   ovf_nxt;

  // Result register.
  logic              vld_r;
  out_data_t         dat_r,   dat_nxt;
  logic [KIND_W-1:0] kind_r,  kind_nxt;
  logic              last_r;

  logic [CHAR_W-1:0] c;
  logic              accept;
  logic              ws, sign;
  logic              begin_tok;
  logic [WC_W-1:0]   wc_dec;
  logic [WC_W+IDX_W-1:0] wc_ext;
  logic [WC_W+IDX_W-1:0] wcr_ext;
  logic [IDX_W-1:0]  cur_idx;
  logic [IDX_W-1:0]  new_idx;

  assign c         = in_tdata[CHAR_W-1:0];
  assign in_tready = !vld_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign ws        = is_ws(c);
  assign sign      = is_sign(c);

  // A byte opens a token when it is text at a token start, or when it breaks
  // a plain word with a sign, or breaks a run of signs with other text.
  always_comb begin
    case (mode_r)
      MODE_BETWEEN: begin_tok = !ws;
      MODE_PLAIN:   begin_tok = sign;
      MODE_SPECIAL: begin_tok = !ws && !sign;
      MODE_QUOTE:   begin_tok = 1'b0;
      MODE_COMMENT: begin_tok = 1'b0;
      default:      begin_tok = !ws;
    endcase
  end

  // Index of the token in progress, taken from the stored count and flag.
  assign wc_dec  = (wc_r != '0) ? (wc_r - WC_W'(1)) : '0;
  assign wc_ext  = {{IDX_W{1'b0}}, wc_dec};
  assign cur_idx = ovf_r ? OVF_IDX : wc_ext[IDX_W-1:0];

  // Index of a token opened by this byte: the next free slot, or the
  // overflow index once the store is full.
  assign wcr_ext = {{IDX_W{1'b0}}, wc_r};
  assign new_idx = (wc_r < WC_MAX) ? wcr_ext[IDX_W-1:0] : OVF_IDX;

  always_comb begin
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    wc_nxt    = wc_r;
    ovf_nxt   = ovf_r;
    dat_nxt   = '0;
    kind_nxt  = KIND_PLAIN;

    if (begin_tok) begin
      if (c == CH_HASH) begin
        // A comment drops the rest of the line.
        mode_nxt = MODE_COMMENT;
      end else begin
        if (wc_r < WC_MAX) begin
          wc_nxt = wc_r + WC_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        dat_nxt.token_start = 1'b1;
        dat_nxt.word_index  = new_idx;
        if (is_quote(c)) begin
          mode_nxt  = MODE_QUOTE;
          quote_nxt = c;
          kind_nxt  = KIND_QUOTED;
        end else if (sign) begin
          mode_nxt         = MODE_SPECIAL;
          kind_nxt         = KIND_SPECIAL;
          dat_nxt.in_token = 1'b1;
        end else begin
          mode_nxt         = MODE_PLAIN;
          kind_nxt         = KIND_PLAIN;
          dat_nxt.in_token = 1'b1;
        end
      end
    end else begin
      case (mode_r)
        MODE_PLAIN, MODE_SPECIAL: begin
          kind_nxt           = (mode_r == MODE_SPECIAL) ? KIND_SPECIAL : KIND_PLAIN;
          dat_nxt.word_index = cur_idx;
          if (ws) begin
            dat_nxt.becomes_terminator = 1'b1;
            mode_nxt                   = MODE_BETWEEN;
          end else begin
            dat_nxt.in_token = 1'b1;
          end
        end
        MODE_QUOTE: begin
          kind_nxt           = KIND_QUOTED;
          dat_nxt.word_index = cur_idx;
          if (c == quote_r) begin
            dat_nxt.becomes_terminator = 1'b1;
            mode_nxt                   = MODE_BETWEEN;
            quote_nxt                  = '0;
          end else begin
            dat_nxt.in_token = 1'b1;
          end
        end
        MODE_COMMENT: begin
          mode_nxt = MODE_COMMENT;
        end
        default: begin
          // Whitespace between tokens, or an unused code falling back.
          mode_nxt = MODE_BETWEEN;
        end
      endcase
    end

    dat_nxt.empty_line     = in_tlast && (wc_nxt == '0) && !ovf_nxt;
    dat_nxt.store_overflow = ovf_nxt;
  end

  // State: updated on each accepted byte, cleared at line end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BETWEEN;
      quote_r <= '0;
      wc_r    <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        mode_r  <= MODE_BETWEEN;
        quote_r <= '0;
        wc_r    <= '0;
        ovf_r   <= 1'b0;
      end else begin
        mode_r  <= mode_nxt;
        quote_r <= quote_nxt;
        wc_r    <= wc_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  // Result register: loads on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dat_r  <= dat_nxt;
      kind_r <= kind_nxt;
      last_r <= in_tlast;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = dat_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  // The line end leaves the lexer between tokens with an empty store.
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> (mode_r == MODE_BETWEEN) && (wc_r == '0) && !ovf_r)
    else $error("lexer state not cleared after line end");

  // The word count never passes the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= WC_MAX)
    else $error("word count exceeds store size");

  // An empty line is only reported on the last beat of a line.
  a_empty_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && dat_r.empty_line |-> out_tlast)
    else $error("empty_line without line_done");

  // A beat that starts a token is never a terminator.
  a_start_not_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && dat_r.token_start |-> !dat_r.becomes_terminator)
    else $error("token start flagged as terminator");
`endif

endmodule

@@ tb/shell_line_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_line_tokenizer_tb
// Self-checking bench for the command line lexer. A short table of
// hand-built lines covers the token kinds, the quote and comment rules and
// the line-end cases. Random lines follow: word, special, quoted and comment
// tokens, noise bytes and lines that overrun the word store. Every result
// beat is checked field by field against a predictor kept in the bench or a result pinned in the table.
// ----------------------------------------------------------------------------
module shell_line_tokenizer_tb;
  import shltok_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int WORD_CAP    = MAX_WORDS_DEF;
  localparam int NUM_RANDOM  = 925;      // least bytes sent in the random part
  localparam int LONG_HOLD   = 150;      // cycles the sink refuses beats once
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP   = 40;       // mismatch lines printed at most

  // One lexer result, laid out for the bench only.
  typedef struct packed {
    logic              start;
    logic [KIND_W-1:0] kind;
    logic              term;
    logic              text;
    logic [IDX_W-1:0]  idx;
    logic              done;
    logic              empty;
    logic              ovf;
  } lex_res_t;

  // A row of the directed table. When pinned is set, the result written in
  // the row is what the block must produce; otherwise the predictor decides.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              pinned;
    lex_res_t          res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic [KIND_W-1:0]   out_tuser;
  logic                out_tlast;

  // Pinned expectation that travels with the byte on the input channel.
  logic                pin_valid;
  lex_res_t            pin_res;

  // Predictor state: lexer mode, open quote byte, stored words, overflow.
  logic [MODE_W-1:0]   lx_mode;
  logic [CHAR_W-1:0]   lx_quote;
  int                  lx_words;
  logic                lx_ovf;

  lex_res_t            lex_exp_q[$];
  logic [CHAR_W-1:0]   line_q[$];
  dir_row_t            dir_tab[$];

  int n_errors    = 0;
  int n_results   = 0;
  int n_bytes     = 0;
  int n_lines     = 0;
  int n_ovf_lines = 0;
  int n_cycles    = 0;
  int burst_left  = 0;
  bit hold_req    = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  shell_line_tokenizer #(
    .MaxWords(WORD_CAP)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Whitespace: space, tab, newline, 0xFF and NUL.
  function automatic bit is_blank(input logic [CHAR_W-1:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_LF, CH_EOF, CH_NUL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] token_idx();
    if (lx_ovf) return IDX_W'(WORD_CAP);
    return (lx_words != 0) ? IDX_W'(lx_words - 1) : '0;
  endfunction

  // A non-blank byte where a token may start: opens a comment, a quoted,
  // a special or a plain token. A token that finds the store full is not
  // counted and marks the rest of the line as overflowed.
  function automatic void open_token(input logic [CHAR_W-1:0] c, inout lex_res_t r);
    if (c == CH_HASH) begin
      lx_mode = MODE_COMMENT;
    end else begin
      if (lx_words < WORD_CAP) lx_words++;
      else lx_ovf = 1'b1;
      r.start = 1'b1;
      r.idx   = token_idx();
      if (c == CH_DQUOT || c == CH_SQUOT || c == CH_BTICK) begin
        lx_mode  = MODE_QUOTE;
        lx_quote = c;
        r.kind   = KIND_QUOTED;
      end else if (c == CH_PIPE || c == CH_GT) begin
        lx_mode = MODE_SPECIAL;
        r.kind  = KIND_SPECIAL;
        r.text  = 1'b1;
      end else begin
        lx_mode = MODE_PLAIN;
        r.kind  = KIND_PLAIN;
        r.text  = 1'b1;
      end
    end
  endfunction

  function automatic lex_res_t lex_byte(input logic [CHAR_W-1:0] c, input logic last);
    lex_res_t r;
    r = '0;
    case (lx_mode)
      MODE_PLAIN: begin
        if (is_blank(c)) begin
          r.term  = 1'b1;
          r.kind  = KIND_PLAIN;
          r.idx   = token_idx();
          lx_mode = MODE_BETWEEN;
        end else if (c == CH_PIPE || c == CH_GT) begin
          open_token(c, r);
        end else begin
          r.text = 1'b1;
          r.kind = KIND_PLAIN;
          r.idx  = token_idx();
        end
      end
      MODE_SPECIAL: begin
        if (is_blank(c)) begin
          r.term  = 1'b1;
          r.kind  = KIND_SPECIAL;
          r.idx   = token_idx();
          lx_mode = MODE_BETWEEN;
        end else if (c == CH_PIPE || c == CH_GT) begin
          r.text = 1'b1;
          r.kind = KIND_SPECIAL;
          r.idx  = token_idx();
        end else begin
          // Any other byte ends the special run and is lexed as a token start.
          open_token(c, r);
        end
      end
      MODE_QUOTE: begin
        r.kind = KIND_QUOTED;
        r.idx  = token_idx();
        if (c == lx_quote) begin
          r.term   = 1'b1;
          lx_mode  = MODE_BETWEEN;
          lx_quote = '0;
        end else begin
          r.text = 1'b1;
        end
      end
      MODE_COMMENT: ;
      default: begin
        lx_mode = MODE_BETWEEN;
        if (!is_blank(c)) open_token(c, r);
      end
    endcase
    r.done = last;
    r.ovf  = lx_ovf;
    if (last) begin
      r.empty  = (lx_words == 0) && !lx_ovf;
      lx_mode  = MODE_BETWEEN;
      lx_quote = '0;
      lx_words = 0;
      lx_ovf   = 1'b0;
    end
    return r;
  endfunction

  // Every byte taken by the block is run through the predictor here, at the
  // same edge at which the block takes it.
  always @(posedge clk) begin : feed
    lex_res_t r;
    if (!rst_n) begin
      lx_mode  = MODE_BETWEEN;
      lx_quote = '0;
      lx_words = 0;
      lx_ovf   = 1'b0;
    end else if (in_tvalid && in_tready) begin
      r = lex_byte(in_tdata[CHAR_W-1:0], in_tlast);
      lex_exp_q.push_back(pin_valid ? pin_res : r);
      n_bytes++;
      if (in_tlast) n_lines++;
      if (in_tlast && r.ovf) n_ovf_lines++;
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report(input string msg);
    if (n_errors < PRINT_CAP) $display("[%0t] result beat %0d: %s", $time, n_results, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Each result beat is held against the oldest expectation.
  always @(posedge clk) begin : chk
    lex_res_t  want;
    out_data_t od;
    if (rst_n && out_tvalid && out_tready) begin
      od = out_tdata;
      if (lex_exp_q.size() == 0) begin
        report("beat arrived with no byte waiting for a result");
      end else begin
        want = lex_exp_q.pop_front();
        check_field("token_start", int'(od.token_start), int'(want.start));
        check_field("token_kind", int'(out_tuser), int'(want.kind));
        check_field("becomes_terminator", int'(od.becomes_terminator), int'(want.term));
        check_field("in_token", int'(od.in_token), int'(want.text));
        check_field("word_index", int'(od.word_index), int'(want.idx));
        check_field("line_done", int'(out_tlast), int'(want.done));
        check_field("empty_line", int'(od.empty_line), int'(want.empty));
        check_field("store_overflow", int'(od.store_overflow), int'(want.ovf));
        check_field("tdata padding", int'(od.pad), 0);
      end
      n_results++;
    end
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               lex_exp_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sink: switches among stall patterns picked at random. On request it
  // refuses beats for a long stretch so the result register fills and the
  // input side has to stall.
  // --------------------------------------------------------------------------
  initial begin : sink
    int pattern;
    int span;
    span = 0;
    pattern = 0;
    out_tready <= 1'b0;
    forever begin
      if (span == 0) begin
        pattern = $urandom_range(0, 3);
        span    = $urandom_range(10, 60);
      end
      span--;
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case (pattern)
          0: out_tready <= 1'b1;                              // always ready
          1: out_tready <= ($urandom_range(0, 99) >= 30);     // light stalls
          2: out_tready <= ~out_tready;                       // alternating
          default: out_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
        endcase
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Source
  // --------------------------------------------------------------------------

  // Offers one byte and returns at the edge where it was taken. Bytes go out
  // in bursts of random length with idle gaps between bursts.
  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last,
                           input logic pin, input lex_res_t pres);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    pin_valid <= pin;
    pin_res   <= pres;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering and waits until every byte sent has its result back.
  // The first edge is always waited out so that the byte taken at the
  // current edge has had its expectation queued.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (lex_exp_q.size() != 0) @(posedge clk);
  endtask

  function automatic lex_res_t mk_res(input int start, input logic [KIND_W-1:0] kind,
                                      input int term, input int text,
                                      input int idx, input int done,
                                      input int empty, input int ovf);
    lex_res_t r;
    r.start = (start != 0);
    r.kind  = kind;
    r.term  = (term != 0);
    r.text  = (text != 0);
    r.idx   = IDX_W'(idx);
    r.done  = (done != 0);
    r.empty = (empty != 0);
    r.ovf   = (ovf != 0);
    return r;
  endfunction

  task automatic add_row(input logic [CHAR_W-1:0] c, input logic last,
                         input logic pin, input lex_res_t r);
    dir_row_t row;
    row.ch     = c;
    row.last   = last;
    row.pinned = pin;
    row.res    = r;
    dir_tab.push_back(row);
  endtask

  function automatic logic [CHAR_W-1:0] blank_byte();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_EOF;
      default: return CH_NUL;
    endcase
  endfunction

  // Any byte that keeps a plain word going; quotes and '#' among them.
  function automatic logic [CHAR_W-1:0] word_byte();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 254));
    while (is_blank(c) || c == CH_PIPE || c == CH_GT);
    return c;
  endfunction

  // Builds one random line. Every sixteenth line may overrun the word store;
  // a few are pure noise; the rest are well-formed token sequences with
  // random content, some of them ending inside an open quote.
  task automatic build_line(input int line_no);
    int               ntok;
    int               style;
    logic [CHAR_W-1:0] q;
    logic [CHAR_W-1:0] c;
    line_q.delete();
    style = $urandom_range(0, 15);
    if (line_no % 16 == 3) begin
      ntok = $urandom_range(WORD_CAP - 1, WORD_CAP + 6);
      repeat (ntok) begin
        line_q.push_back(CHAR_W'(8'h61 + $urandom_range(0, 25)));
        line_q.push_back(blank_byte());
      end
    end else if (style < 2) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) line_q.push_back(blank_byte());
      ntok = $urandom_range(0, 7);
      repeat (ntok) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            repeat ($urandom_range(1, 6)) line_q.push_back(word_byte());
          end
          4, 5: begin
            repeat ($urandom_range(1, 3))
              line_q.push_back(($urandom_range(0, 1) != 0) ? CH_PIPE : CH_GT);
          end
          6, 7, 8: begin
            case ($urandom_range(0, 2))
              0: q = CH_DQUOT;
              1: q = CH_SQUOT;
              default: q = CH_BTICK;
            endcase
            line_q.push_back(q);
            repeat ($urandom_range(0, 6)) begin
              c = CHAR_W'($urandom_range(0, 255));
              if (c != q) line_q.push_back(c);
            end
            // Now and then the quote is left open up to the line end.
            if ($urandom_range(0, 7) != 0) line_q.push_back(q);
          end
          default: begin
            line_q.push_back(CH_HASH);
            repeat ($urandom_range(0, 5)) line_q.push_back(CHAR_W'($urandom_range(0, 255)));
          end
        endcase
        // Tokens are mostly parted by whitespace, sometimes butted together.
        if ($urandom_range(0, 4) != 0)
          repeat ($urandom_range(1, 2)) line_q.push_back(blank_byte());
      end
      if (line_q.size() == 0) line_q.push_back(blank_byte());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    int n_sent;
    int line_no;
    bit hold_asked;
    lex_res_t none;

    none       = '0;
    n_sent     = 0;
    line_no    = 0;
    hold_asked = 1'b0;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    pin_valid <= 1'b0;
    pin_res   <= '0;

    // A line of a single NUL: nothing found, the line is empty.
    add_row(CH_NUL, 1'b1, 1'b1, mk_res(0, KIND_PLAIN, 0, 0, 0, 1, 1, 0));
    // "ab|>" then a double-quoted token holding '#' and 0xFF, then a comment
    // that swallows the rest of the line.
    add_row(8'h61, 1'b0, 1'b1, mk_res(1, KIND_PLAIN, 0, 1, 0, 0, 0, 0));   // a
    add_row(8'h62, 1'b0, 1'b0, none);                                     // b
    add_row(CH_PIPE, 1'b0, 1'b1, mk_res(1, KIND_SPECIAL, 0, 1, 1, 0, 0, 0));
    add_row(CH_GT, 1'b0, 1'b0, none);
    add_row(CH_DQUOT, 1'b0, 1'b1, mk_res(1, KIND_QUOTED, 0, 0, 2, 0, 0, 0));
    add_row(CH_HASH, 1'b0, 1'b0, none);
    add_row(CH_EOF, 1'b0, 1'b0, none);
    add_row(CH_DQUOT, 1'b0, 1'b0, none);
    add_row(CH_HASH, 1'b0, 1'b0, none);
    add_row(8'h7A, 1'b0, 1'b0, none);                                     // z
    add_row(CH_LF, 1'b1, 1'b0, none);
    // Hash and backtick inside a word are text; a tab ends the word; a
    // single quote then stays open to the line end.
    add_row(8'h78, 1'b0, 1'b0, none);                                     // x
    add_row(CH_HASH, 1'b0, 1'b0, none);
    add_row(CH_BTICK, 1'b0, 1'b0, none);
    add_row(CH_TAB, 1'b0, 1'b0, none);
    add_row(CH_SQUOT, 1'b0, 1'b0, none);
    add_row(8'h71, 1'b1, 1'b0, none);                                     // q
    // "|a>": a special, a word right after it, and a special that the line
    // end closes without a terminator.
    add_row(CH_PIPE, 1'b0, 1'b0, none);
    add_row(8'h61, 1'b0, 1'b0, none);                                     // a
    add_row(CH_GT, 1'b1, 1'b0, none);
    // A line that is only a comment counts as empty.
    add_row(CH_HASH, 1'b1, 1'b1, mk_res(0, KIND_PLAIN, 0, 0, 0, 1, 1, 0));
    // A comment opened right after a special token.
    add_row(CH_GT, 1'b0, 1'b0, none);
    add_row(CH_HASH, 1'b0, 1'b0, none);
    add_row(CH_EOF, 1'b1, 1'b0, none);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_byte(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].pinned,
                                   dir_tab[i].res);
    wait_drained();

    while (n_sent < NUM_RANDOM) begin
      build_line(line_no);
      foreach (line_q[j]) send_byte(line_q[j], j == line_q.size() - 1, 1'b0, none);
      n_sent += line_q.size();
      line_no++;
      // Once over 300 bytes have gone out, have the sink hold off while bytes keep coming.
      if (!hold_asked && n_sent > 300) begin
        hold_req   = 1'b1;
        hold_asked = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Lexed %0d bytes in %0d lines, %0d of them past the %0d-word store.",
             n_bytes, n_lines, n_ovf_lines, WORD_CAP);
    $display("Checked %0d result beats with %0d mismatches.", n_results, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
